>>> rtl/core/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// shared constants, codes and control types of the distance sum swap sampler
// ----------------------------------------------------------------------------
package dss_pkg;

    // population and slot geometry
    localparam int MAX_UNITS  = 256;
    localparam int UNIT_BITS  = 8;
    localparam int CODE_BITS  = 9;

    // payload field widths
    localparam int ACT_BITS   = 2;
    localparam int DIST_IN_BITS = 32;
    localparam int U_BITS     = 16;
    localparam int POP_BITS   = 9;
    localparam int SAMP_BITS  = 8;
    localparam int BETA_BITS  = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;

    // parameter defaults
    localparam int DIST_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // reset values of the registers
    localparam logic [POP_BITS-1:0]  POP_RESET    = 9'd256;
    localparam logic [SAMP_BITS-1:0] SAMPLE_RESET = 8'd16;
    localparam logic [BETA_BITS-1:0] BETA_RESET   = 6'd10;

    // action codes
    localparam logic [ACT_BITS-1:0] ACT_LOAD_DIST = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_LOAD_SLOT = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_PROPOSE   = 2'd2;
    localparam logic [ACT_BITS-1:0] ACT_READ_SLOT = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_POP_SIZE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_SIZE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BETA        = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;      // take the input transfer
        logic dist_wr;    // distance load
        logic slot_wr;    // order slot load
        logic rd_slot;    // order read for a slot read
        logic get_read;   // capture read unit
        logic pick;       // choose inside and outside slots
        logic rd_w;       // order read at inside slot
        logic rd_k;       // order read at outside slot
        logic get_cw;     // capture inside unit
        logic get_ck;     // capture outside unit, clear sums
        logic rd_ord_i;   // order read at loop slot
        logic rd_dc;      // distance read inside unit to loop unit
        logic rd_db;      // distance read outside unit to loop unit
        logic acc_c;      // add to inside sum
        logic acc_b;      // add to outside sum, step loop
        logic rd_pair;    // distance read outside to inside unit
        logic sub_pair;   // take pair distance off outside sum
        logic div_init;   // start ratio division
        logic div_step;   // one restoring step
        logic pow_p;      // multiply power by base
        logic pow_b;      // square base
        logic swap_w;     // write outside unit to inside slot
        logic swap_k;     // write inside unit to outside slot
        logic out_load;   // move result into output register
    } dss_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [ACT_BITS-1:0] action;
        logic degenerate;
        logic last_i;
        logic early_dec;
        logic early_acc;
        logic div_last;
        logic exp_last;
        logic cmp_acc;
    } dss_sts_t;

endpackage

>>> rtl/core/dss_ctrl.sv
// ----------------------------------------------------------------------------
// dss_ctrl
// sequencing state machine of the distance sum swap sampler
// ----------------------------------------------------------------------------
module dss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  dss_pkg::dss_sts_t sts,
    output dss_pkg::dss_cmd_t cmd
);

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_DECODE = 20'h00002,
        ST_RDOUT  = 20'h00004,
        ST_RD_W   = 20'h00008,
        ST_RD_K   = 20'h00010,
        ST_GET_K  = 20'h00020,
        ST_L_ORD  = 20'h00040,
        ST_L_DC   = 20'h00080,
        ST_L_DB   = 20'h00100,
        ST_L_ACC  = 20'h00200,
        ST_PAIR   = 20'h00400,
        ST_PAIR_W = 20'h00800,
        ST_DECIDE = 20'h01000,
        ST_DIV    = 20'h02000,
        ST_POW_P  = 20'h04000,
        ST_POW_B  = 20'h08000,
        ST_CMP    = 20'h10000,
        ST_SWAP_W = 20'h20000,
        ST_SWAP_K = 20'h40000,
        ST_FIN    = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg & ~m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.action)
                    dss_pkg::ACT_LOAD_DIST: begin
                        cmd.dist_wr = 1'b1;
                        state_next  = ST_FIN;
                    end
                    dss_pkg::ACT_LOAD_SLOT: begin
                        cmd.slot_wr = 1'b1;
                        state_next  = ST_FIN;
                    end
                    dss_pkg::ACT_READ_SLOT: begin
                        cmd.rd_slot = 1'b1;
                        state_next  = ST_RDOUT;
                    end
                    default: begin
                        cmd.pick   = 1'b1;
                        state_next = sts.degenerate ? ST_FIN : ST_RD_W;
                    end
                endcase
            end
            ST_RDOUT: begin
                cmd.get_read = 1'b1;
                state_next   = ST_FIN;
            end
            ST_RD_W: begin
                cmd.rd_w   = 1'b1;
                state_next = ST_RD_K;
            end
            ST_RD_K: begin
                cmd.get_cw = 1'b1;
                cmd.rd_k   = 1'b1;
                state_next = ST_GET_K;
            end
            ST_GET_K: begin
                cmd.get_ck = 1'b1;
                state_next = ST_L_ORD;
            end
            ST_L_ORD: begin
                cmd.rd_ord_i = 1'b1;
                state_next   = ST_L_DC;
            end
            ST_L_DC: begin
                cmd.rd_dc  = 1'b1;
                state_next = ST_L_DB;
            end
            ST_L_DB: begin
                cmd.rd_db  = 1'b1;
                cmd.acc_c  = 1'b1;
                state_next = ST_L_ACC;
            end
            ST_L_ACC: begin
                cmd.acc_b  = 1'b1;
                state_next = sts.last_i ? ST_PAIR : ST_L_ORD;
            end
            ST_PAIR: begin
                cmd.rd_pair = 1'b1;
                state_next  = ST_PAIR_W;
            end
            ST_PAIR_W: begin
                cmd.sub_pair = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (sts.early_dec) begin
                    state_next = sts.early_acc ? ST_SWAP_W : ST_FIN;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_POW_P;
                end
            end
            ST_POW_P: begin
                cmd.pow_p  = 1'b1;
                state_next = ST_POW_B;
            end
            ST_POW_B: begin
                cmd.pow_b  = 1'b1;
                state_next = sts.exp_last ? ST_CMP : ST_POW_P;
            end
            ST_CMP: begin
                state_next = sts.cmp_acc ? ST_SWAP_W : ST_FIN;
            end
            ST_SWAP_W: begin
                cmd.swap_w = 1'b1;
                state_next = ST_SWAP_K;
            end
            ST_SWAP_K: begin
                cmd.swap_k = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> rtl/core/dss_dpath.sv
// ----------------------------------------------------------------------------
// dss_dpath
// stores, sums, ratio divider and power unit of the distance sum swap sampler
// ----------------------------------------------------------------------------
module dss_dpath #(
    parameter int DIST_BITS = dss_pkg::DIST_BITS_DEF,
    parameter int FRAC_BITS = dss_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  dss_pkg::dss_cmd_t                  cmd,
    output dss_pkg::dss_sts_t                  sts,
    input  logic [dss_pkg::ACT_BITS-1:0]       s_action,
    input  logic [dss_pkg::UNIT_BITS-1:0]      s_row_index,
    input  logic [dss_pkg::UNIT_BITS-1:0]      s_col_index,
    input  logic [dss_pkg::DIST_IN_BITS-1:0]   s_distance,
    input  logic [dss_pkg::CODE_BITS-1:0]      s_unit_code,
    input  logic [dss_pkg::U_BITS-1:0]         s_u_pick_in,
    input  logic [dss_pkg::U_BITS-1:0]         s_u_pick_out,
    input  logic [dss_pkg::U_BITS-1:0]         s_u_accept,
    input  logic                               cfg_wr_en,
    input  logic [dss_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [dss_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    output logic [dss_pkg::CODE_BITS-1:0]      m_read_unit,
    output logic                               m_accepted,
    output logic [dss_pkg::UNIT_BITS-1:0]      m_inside_slot,
    output logic [dss_pkg::UNIT_BITS-1:0]      m_outside_slot
);

    localparam int UB       = dss_pkg::UNIT_BITS;
    localparam int CB       = dss_pkg::CODE_BITS;
    localparam int UW       = dss_pkg::U_BITS;
    localparam int SUM_BITS = DIST_BITS + UB;
    localparam int CNT_BITS = $clog2(FRAC_BITS);
    localparam int EB       = dss_pkg::BETA_BITS;
    localparam int CMP_BITS = FRAC_BITS + UW + 1;

    // configuration
    logic [dss_pkg::POP_BITS-1:0]  pop_reg;
    logic [dss_pkg::SAMP_BITS-1:0] samp_reg;
    logic [EB-1:0]                 beta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_reg  <= dss_pkg::POP_RESET;
            samp_reg <= dss_pkg::SAMPLE_RESET;
            beta_reg <= dss_pkg::BETA_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dss_pkg::CFG_POP_SIZE:    pop_reg  <= cfg_wr_data;
                dss_pkg::CFG_SAMPLE_SIZE: samp_reg <= cfg_wr_data[UB-1:0];
                dss_pkg::CFG_BETA:        beta_reg <= cfg_wr_data[EB-1:0];
                default: ;
            endcase
        end
    end

    // latched item
    logic [dss_pkg::ACT_BITS-1:0] act_reg;
    logic [UB-1:0]                row_reg, col_reg;
    logic [DIST_BITS-1:0]         dist_in_reg;
    logic [CB-1:0]                code_reg;
    logic [UW-1:0]                upi_reg, upo_reg, uac_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            act_reg     <= s_action;
            row_reg     <= s_row_index;
            col_reg     <= s_col_index;
            dist_in_reg <= DIST_BITS'(s_distance);
            code_reg    <= s_unit_code;
            upi_reg     <= s_u_pick_in;
            upo_reg     <= s_u_pick_out;
            uac_reg     <= s_u_accept;
        end
    end

    // slot choice
    logic [CB-1:0]      n_use, n_minus_s;
    logic [UB+UW-1:0]   w_prod;
    logic [CB+UW-1:0]   k_prod;
    logic [UB-1:0]      w_pick, k_pick;
    logic               degenerate;

    assign n_use      = (pop_reg > CB'(dss_pkg::MAX_UNITS)) ? CB'(dss_pkg::MAX_UNITS) : pop_reg;
    assign degenerate = (samp_reg == '0) || ({1'b0, samp_reg} >= n_use);
    assign n_minus_s  = n_use - {1'b0, samp_reg};
    assign w_prod     = upi_reg * samp_reg;
    assign k_prod     = upo_reg * n_minus_s;
    assign w_pick     = w_prod[UB+UW-1:UW];
    assign k_pick     = samp_reg + k_prod[UW+UB-1:UW];

    // order store
    logic [CB-1:0] order_mem [dss_pkg::MAX_UNITS];
    logic [CB-1:0] ord_q_reg;
    logic          ord_we, ord_re;
    logic [UB-1:0] ord_wa, ord_ra, w_reg, k_reg, i_reg;
    logic [CB-1:0] ord_wd, cw_reg, ck_reg;

    assign ord_we = cmd.slot_wr | cmd.swap_w | cmd.swap_k;
    assign ord_re = cmd.rd_slot | cmd.rd_w | cmd.rd_k | cmd.rd_ord_i;

    always_comb begin
        ord_wa = row_reg;
        ord_wd = code_reg;
        if (cmd.swap_w) begin
            ord_wa = w_reg;
            ord_wd = ck_reg;
        end else if (cmd.swap_k) begin
            ord_wa = k_reg;
            ord_wd = cw_reg;
        end
        ord_ra = i_reg;
        if (cmd.rd_slot) begin
            ord_ra = row_reg;
        end else if (cmd.rd_w) begin
            ord_ra = w_reg;
        end else if (cmd.rd_k) begin
            ord_ra = k_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            order_mem[ord_wa] <= ord_wd;
        end
        if (ord_re) begin
            ord_q_reg <= order_mem[ord_ra];
        end
    end

    // distance store, addressed by zero-based unit pair
    logic [DIST_BITS-1:0] dist_mem [dss_pkg::MAX_UNITS * dss_pkg::MAX_UNITS];
    logic [DIST_BITS-1:0] dist_q_reg;
    logic                 dist_ok_reg;
    logic                 dist_re, pair_ok;
    logic [CB-1:0]        code_a, code_b, ca_m1, cb_m1;
    logic [2*UB-1:0]      dist_ra;

    assign dist_re = cmd.rd_dc | cmd.rd_db | cmd.rd_pair;

    always_comb begin
        code_a = cw_reg;
        code_b = ord_q_reg;
        if (cmd.rd_db) begin
            code_a = ck_reg;
        end else if (cmd.rd_pair) begin
            code_a = ck_reg;
            code_b = cw_reg;
        end
        ca_m1   = code_a - 1'b1;
        cb_m1   = code_b - 1'b1;
        pair_ok = (code_a != '0) && (code_b != '0) && !ca_m1[CB-1] && !cb_m1[CB-1];
        dist_ra = {ca_m1[UB-1:0], cb_m1[UB-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (cmd.dist_wr) begin
            dist_mem[{row_reg, col_reg}] <= dist_in_reg;
        end
        if (dist_re) begin
            dist_q_reg  <= dist_mem[dist_ra];
            dist_ok_reg <= pair_ok;
        end
    end

    logic [SUM_BITS-1:0] dist_ext;
    assign dist_ext = dist_ok_reg ? SUM_BITS'(dist_q_reg) : '0;

    // sums and loop index
    logic [SUM_BITS-1:0] totc_reg, totb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            w_reg <= '0;
            k_reg <= '0;
        end else if (cmd.pick && !degenerate) begin
            w_reg <= w_pick;
            k_reg <= k_pick;
        end
        if (cmd.get_cw) begin
            cw_reg <= ord_q_reg;
        end
        if (cmd.get_ck) begin
            ck_reg   <= ord_q_reg;
            totc_reg <= '0;
            totb_reg <= '0;
            i_reg    <= '0;
        end else begin
            if (cmd.acc_c) begin
                totc_reg <= totc_reg + dist_ext;
            end
            if (cmd.acc_b) begin
                totb_reg <= totb_reg + dist_ext;
                i_reg    <= i_reg + 1'b1;
            end
            if (cmd.sub_pair) begin
                totb_reg <= totb_reg - dist_ext;
            end
        end
    end

    // restoring division of totb by totc, FRAC_BITS quotient bits
    logic [SUM_BITS-1:0]  rem_reg;
    logic [SUM_BITS:0]    rem2;
    logic                 rem_ge;
    logic [FRAC_BITS-1:0] q_reg, q_next;
    logic [CNT_BITS-1:0]  div_cnt_reg;

    assign rem2   = {rem_reg, 1'b0};
    assign rem_ge = rem2 >= {1'b0, totc_reg};
    assign q_next = {q_reg[FRAC_BITS-2:0], rem_ge};

    // power by square and multiply, one shared multiplier
    logic [FRAC_BITS:0]       p_reg;
    logic [FRAC_BITS-1:0]     base_reg;
    logic [EB-1:0]            e_reg;
    logic [FRAC_BITS:0]       mul_a;
    logic [2*FRAC_BITS:0]     mul_y;

    assign mul_a = cmd.pow_p ? p_reg : {1'b0, base_reg};
    assign mul_y = mul_a * base_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg     <= totb_reg;
            q_reg       <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_ge ? SUM_BITS'(rem2 - {1'b0, totc_reg}) : rem2[SUM_BITS-1:0];
            q_reg       <= q_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_cnt_reg == CNT_BITS'(FRAC_BITS - 1)) begin
                base_reg <= q_next;
                p_reg    <= {1'b1, {FRAC_BITS{1'b0}}};
                e_reg    <= beta_reg;
            end
        end
        if (cmd.pow_p && e_reg[0]) begin
            p_reg <= mul_y[2*FRAC_BITS:FRAC_BITS];
        end
        if (cmd.pow_b) begin
            base_reg <= mul_y[2*FRAC_BITS-1:FRAC_BITS];
            e_reg    <= e_reg >> 1;
        end
    end

    logic [CMP_BITS-1:0] cmp_lhs, cmp_rhs;
    assign cmp_lhs = {1'b0, uac_reg, {FRAC_BITS{1'b0}}};
    assign cmp_rhs = {p_reg, {UW{1'b0}}};

    // result
    logic [CB-1:0] res_unit_reg;
    logic          res_acc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            res_unit_reg <= '0;
            res_acc_reg  <= 1'b0;
        end else begin
            if (cmd.get_read) begin
                res_unit_reg <= ord_q_reg;
            end
            if (cmd.swap_k) begin
                res_acc_reg <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            m_read_unit    <= res_unit_reg;
            m_accepted     <= res_acc_reg;
            m_inside_slot  <= w_reg;
            m_outside_slot <= k_reg;
        end
    end

    // status
    always_comb begin
        sts            = '0;
        sts.action     = act_reg;
        sts.degenerate = degenerate;
        sts.last_i     = (i_reg == samp_reg - 1'b1);
        sts.early_dec  = (totc_reg == '0) || (beta_reg == '0) || (totb_reg >= totc_reg);
        sts.early_acc  = (totc_reg == '0) ? (totb_reg != '0) : 1'b1;
        sts.div_last   = (div_cnt_reg == CNT_BITS'(FRAC_BITS - 1));
        sts.exp_last   = ((e_reg >> 1) == '0);
        sts.cmp_acc    = cmp_lhs < cmp_rhs;
    end

endmodule

>>> rtl/core/distance_sum_swap_sampler.sv
// ----------------------------------------------------------------------------
// distance_sum_swap_sampler
// swap proposal and acceptance step of a distance-sum spatial sampler
// ----------------------------------------------------------------------------
//
// channel   direction  handshake           payload
// s_*       in         s_valid / s_ready   action, indexes, distance, code, fractions
// m_*       out        m_valid / m_ready   read_unit, accepted, inside/outside slot
// cfg_*     in         cfg_wr_en           cfg_index, cfg_wr_data
//
// one item at a time; a load goes from decode to the finish state, a slot read via a read-out state
// a proposal is paced by the single read port of the distance and order memories
// (two distance reads per sample slot) and the bit-serial ratio divider
// reset clears the controller and the configuration registers; the memories are not cleared
// a stalled result holds in the output register; the next transfer is taken
// once that result has moved there
//
module distance_sum_swap_sampler #(
    parameter int DIST_BITS = dss_pkg::DIST_BITS_DEF,
    parameter int FRAC_BITS = dss_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [dss_pkg::ACT_BITS-1:0]       s_action,
    input  logic [dss_pkg::UNIT_BITS-1:0]      s_row_index,
    input  logic [dss_pkg::UNIT_BITS-1:0]      s_col_index,
    input  logic [dss_pkg::DIST_IN_BITS-1:0]   s_distance,
    input  logic [dss_pkg::CODE_BITS-1:0]      s_unit_code,
    input  logic [dss_pkg::U_BITS-1:0]         s_u_pick_in,
    input  logic [dss_pkg::U_BITS-1:0]         s_u_pick_out,
    input  logic [dss_pkg::U_BITS-1:0]         s_u_accept,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [dss_pkg::CODE_BITS-1:0]      m_read_unit,
    output logic                               m_accepted,
    output logic [dss_pkg::UNIT_BITS-1:0]      m_inside_slot,
    output logic [dss_pkg::UNIT_BITS-1:0]      m_outside_slot,
    // register writes
    input  logic                               cfg_wr_en,
    input  logic [dss_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [dss_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data
);

    // command and status between sequencer and datapath
    dss_pkg::dss_cmd_t cmd;
    dss_pkg::dss_sts_t sts;

    // sequencer: decode, slot loop, divider and power steps, result hand-off
    dss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: memories, distance sums, ratio and acceptance test
    dss_dpath #(
        .DIST_BITS (DIST_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_action       (s_action),
        .s_row_index    (s_row_index),
        .s_col_index    (s_col_index),
        .s_distance     (s_distance),
        .s_unit_code    (s_unit_code),
        .s_u_pick_in    (s_u_pick_in),
        .s_u_pick_out   (s_u_pick_out),
        .s_u_accept     (s_u_accept),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .m_read_unit    (m_read_unit),
        .m_accepted     (m_accepted),
        .m_inside_slot  (m_inside_slot),
        .m_outside_slot (m_outside_slot)
    );

endmodule
